FILE: sv/ncs_pkg.sv
`default_nettype none
package ncs_pkg;

	localparam int unsigned InDepth = 4;
	localparam int unsigned OutDepth = 2;

	localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
	localparam logic [10:0] ExpMax = 11'h7FF;

	// one queued addend, classified on entry
	typedef struct packed {
		logic [63:0] value;
		logic        last;
		logic        nonfinite;
	} item_t;

	// one finished result
	typedef struct packed {
		logic [63:0] total;
		logic        status;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_ERR1,
		BK_ERR2,
		BK_CORR,
		BK_FINAL,
		BK_PUSH
	} back_state_t;

	// leading zero count of a 56-bit word
	function automatic logic [5:0] lzc56(input logic [55:0] x);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (x[i]) n = 6'(55 - i);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ncs_front.sv
`default_nettype none
module ncs_front import ncs_pkg::*; #(
	parameter int unsigned IN_DEPTH = InDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [63:0] value_bits,
	input  wire logic        end_of_run,
	output      item_t       item,
	output      logic        avail,
	input  wire logic        take
);
	localparam int unsigned PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int unsigned CW = $clog2(IN_DEPTH + 1);

	item_t          mem_q [IN_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;
	item_t          new_item;

	assign full  = (cnt_q == CW'(IN_DEPTH));
	assign avail = (cnt_q != '0);
	assign do_wr = push && !full;
	assign do_rd = take && avail;
	assign item  = mem_q[rd_q];

	// classify: all-ones exponent means infinity or NaN
	always_comb begin
		new_item.value     = value_bits;
		new_item.last      = end_of_run;
		new_item.nonfinite = (value_bits[62:52] == ExpMax);
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wr_q <= (wr_q == PW'(IN_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_rd) rd_q <= (rd_q == PW'(IN_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end

endmodule
`default_nettype wire

FILE: sv/ncs_fadd.sv
`default_nettype none
module ncs_fadd import ncs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        op_valid,
	input  wire logic [63:0] op_a,
	input  wire logic [63:0] op_b,
	input  wire logic        op_sub,
	output      logic        res_valid,
	output      logic [63:0] res
);
	// stage 1: specials, swap, align
	logic        v_s1, spec_s1, sign_s1, diff_s1;
	logic [63:0] sres_s1;
	logic [11:0] ex_s1;
	logic [55:0] mx_s1, al_s1;

	logic [63:0] b_eff, x, y;
	logic        a_nan, b_nan, a_inf, b_inf, spec;
	logic [63:0] sres;
	logic [11:0] ex, ey, d;
	logic [52:0] my;
	logic [111:0] sh;
	logic [55:0] al;

	always_comb begin
		b_eff = {op_b[63] ^ op_sub, op_b[62:0]};
		a_nan = (op_a[62:52] == ExpMax) && (op_a[51:0] != '0);
		b_nan = (op_b[62:52] == ExpMax) && (op_b[51:0] != '0);
		a_inf = (op_a[62:52] == ExpMax) && (op_a[51:0] == '0);
		b_inf = (op_b[62:52] == ExpMax) && (op_b[51:0] == '0);
		spec  = 1'b1;
		sres  = '0;
		if (a_nan) sres = op_a | 64'h0008_0000_0000_0000;
		else if (b_nan) sres = op_b | 64'h0008_0000_0000_0000;
		else if (a_inf && b_inf && (op_a[63] != b_eff[63])) sres = DefaultNan;
		else if (a_inf) sres = op_a;
		else if (b_inf) sres = b_eff;
		else spec = 1'b0;
		if (b_eff[62:0] > op_a[62:0]) begin
			x = b_eff;
			y = op_a;
		end else begin
			x = op_a;
			y = b_eff;
		end
		ex = (x[62:52] == '0) ? 12'd1 : {1'b0, x[62:52]};
		ey = (y[62:52] == '0) ? 12'd1 : {1'b0, y[62:52]};
		my = {y[62:52] != '0, y[51:0]};
		d  = ex - ey;
		sh = {my, 3'b000, 56'd0} >> d[6:0];
		if (d >= 12'd56) al = {55'd0, my != '0};
		else al = {sh[111:57], sh[56] | (sh[55:0] != '0)};
	end

	always_ff @(posedge clk) begin
		spec_s1 <= spec;
		sres_s1 <= sres;
		sign_s1 <= x[63];
		diff_s1 <= x[63] ^ y[63];
		ex_s1   <= ex;
		mx_s1   <= {x[62:52] != '0, x[51:0], 3'b000};
		al_s1   <= al;
	end

	// stage 2: magnitude add or subtract
	logic        v_s2, spec_s2, sign_s2, diff_s2;
	logic [63:0] sres_s2;
	logic [11:0] ex_s2;
	logic [56:0] sum_s2;

	always_ff @(posedge clk) begin
		spec_s2 <= spec_s1;
		sres_s2 <= sres_s1;
		sign_s2 <= sign_s1;
		diff_s2 <= diff_s1;
		ex_s2   <= ex_s1;
		sum_s2  <= diff_s1 ? ({1'b0, mx_s1} - {1'b0, al_s1})
		                   : ({1'b0, mx_s1} + {1'b0, al_s1});
	end

	// stage 3: normalize and round to nearest even
	logic [63:0] res_s3;
	logic [63:0] r;
	logic [55:0] n;
	logic [11:0] e, lim;
	logic [5:0]  lz, sa;
	logic [53:0] rm;
	logic [52:0] m53;
	logic        inc;

	always_comb begin
		lz  = lzc56(sum_s2[55:0]);
		lim = ex_s2 - 12'd1;
		sa  = ({6'd0, lz} < lim) ? lz : lim[5:0];
		if (sum_s2[56]) begin
			n = {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			e = ex_s2 + 12'd1;
		end else begin
			n = sum_s2[55:0] << sa;
			e = ex_s2 - {6'd0, sa};
		end
		inc = n[2] & ((n[1:0] != '0) | n[3]);
		rm  = {1'b0, n[55:3]} + {53'd0, inc};
		if (rm[53]) begin
			m53 = rm[53:1];
			e   = e + 12'd1;
		end else begin
			m53 = rm[52:0];
		end
		if (spec_s2) r = sres_s2;
		else if (sum_s2 == '0) r = {diff_s2 ? 1'b0 : sign_s2, 63'd0};
		else if (e >= 12'd2047) r = {sign_s2, ExpMax, 52'd0};
		else r = {sign_s2, m53[52] ? e[10:0] : 11'd0, m53[51:0]};
	end

	always_ff @(posedge clk) begin
		res_s3 <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s1 <= op_valid;
			v_s2 <= v_s1;
			res_valid <= v_s2;
		end
	end

	assign res = res_s3;

endmodule
`default_nettype wire

FILE: sv/ncs_back.sv
`default_nettype none
module ncs_back import ncs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire logic        avail,
	output      logic        take,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [63:0] total_bits,
	output      logic        status
);
	back_state_t state_q, state_d;
	logic [63:0] s_q, c_q, v_q, t_q, e_q;
	logic        bad_q, last_q, ge_q, wait_q;

	logic        op_valid, res_valid, op_sub, fire, oq_full, do_push, do_pop;
	logic [63:0] op_a, op_b, res;

	// output queue
	result_t     oq_q [OutDepth];
	logic        oq_wr_q, oq_rd_q;
	logic [1:0]  oq_cnt_q;
	result_t     push_data;

	ncs_fadd u_fadd (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_a      (op_a),
		.op_b      (op_b),
		.op_sub    (op_sub),
		.res_valid (res_valid),
		.res       (res)
	);

	// sequencer: next state and adder operands
	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		op_valid = 1'b0;
		op_a     = s_q;
		op_b     = v_q;
		op_sub   = 1'b0;
		do_push  = 1'b0;
		fire     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (avail) begin
					take = 1'b1;
					if (item.nonfinite) state_d = item.last ? BK_FINAL : BK_IDLE;
					else state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				fire = 1'b1;
				if (res_valid) state_d = BK_ERR1;
			end
			BK_ERR1: begin
				fire   = 1'b1;
				op_a   = ge_q ? s_q : v_q;
				op_b   = t_q;
				op_sub = 1'b1;
				if (res_valid) state_d = BK_ERR2;
			end
			BK_ERR2: begin
				fire = 1'b1;
				op_a = e_q;
				op_b = ge_q ? v_q : s_q;
				if (res_valid) state_d = BK_CORR;
			end
			BK_CORR: begin
				fire = 1'b1;
				op_a = c_q;
				op_b = e_q;
				if (res_valid) state_d = last_q ? BK_FINAL : BK_IDLE;
			end
			BK_FINAL: begin
				op_b = c_q;
				if (bad_q) state_d = BK_PUSH;
				else begin
					fire = 1'b1;
					if (res_valid) state_d = BK_PUSH;
				end
			end
			BK_PUSH: begin
				if (!oq_full) begin
					do_push = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		op_valid = fire && !wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// running state and scratch values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= '0;
			c_q    <= '0;
			bad_q  <= 1'b0;
			wait_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (op_valid) wait_q <= 1'b1;
			else if (res_valid) wait_q <= 1'b0;
			if (take) begin
				if (item.nonfinite) bad_q <= 1'b1;
				last_q <= item.last;
			end
			if (state_q == BK_CORR && res_valid) begin
				c_q <= res;
				s_q <= t_q;
			end
			if (do_push) begin
				s_q   <= '0;
				c_q   <= '0;
				bad_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			v_q  <= item.value;
			ge_q <= !((s_q[62:52] == ExpMax) && (s_q[51:0] != '0))
			        && (s_q[62:0] >= item.value[62:0]);
		end
		if (res_valid) begin
			if (state_q == BK_SUM) t_q <= res;
			else e_q <= res;
		end
	end

	// output queue of two results
	assign oq_full          = (oq_cnt_q == 2'(OutDepth));
	assign empty            = (oq_cnt_q == '0);
	assign do_pop           = pop && !empty;
	assign push_data.total  = bad_q ? 64'd0 : e_q;
	assign push_data.status = bad_q;
	assign total_bits       = oq_q[oq_rd_q].total;
	assign status           = oq_q[oq_rd_q].status;

	always_ff @(posedge clk) begin
		if (do_push) oq_q[oq_wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (do_push) oq_wr_q <= !oq_wr_q;
			if (do_pop) oq_rd_q <= !oq_rd_q;
			oq_cnt_q <= oq_cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_res_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> wait_q) else $error("adder result with no op in flight");
	a_no_issue_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> !op_valid) else $error("adder op issued while one is in flight");
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= 2'(OutDepth)) else $error("output queue overflow");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (state_q == BK_IDLE && !wait_q)) else $error("item taken mid-operation");
`endif

endmodule
`default_nettype wire

FILE: sv/neumaier_compensated_sum.sv
`default_nettype none
// Neumaier compensated sum of binary64 values, round to nearest even. Items
// enter an input queue of IN_DEPTH entries, where infinities and NaNs are
// flagged; a sequencer drives one three-stage floating-point adder. A finite
// item is taken and then runs four dependent adds (sum, two error terms,
// correction), each issued only after the previous result returns; the last
// item of a run adds one more add (sum plus correction) and the push into a
// two-entry result queue. A non-finite item is taken without any add. A run
// holding a non-finite value returns total_bits zero with status 1.
module neumaier_compensated_sum import ncs_pkg::*; #(
	parameter int unsigned IN_DEPTH = InDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [63:0] value_bits,
	input  wire logic        end_of_run,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [63:0] total_bits,
	output      logic        status
);
	item_t item;
	logic  avail, take;

	ncs_front #(.IN_DEPTH(IN_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value_bits (value_bits),
		.end_of_run (end_of_run),
		.item       (item),
		.avail      (avail),
		.take       (take)
	);

	ncs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.avail      (avail),
		.take       (take),
		.empty      (empty),
		.pop        (pop),
		.total_bits (total_bits),
		.status     (status)
	);

endmodule
`default_nettype wire
